/* rtl/core/ifb_pkg.sv */
package ifb_pkg;

   localparam logic [7:0] FLAG_BYTE  = 8'h7E;
   localparam logic [7:0] ESC_BYTE   = 8'h7D;
   localparam logic [7:0] ESC_XOR    = 8'h20;
   localparam logic [7:0] ADDR_RESET = 8'h05;
   localparam logic [7:0] CTRL_SEQ0  = 8'h00;
   localparam logic [7:0] CTRL_SEQ1  = 8'h02;

   localparam logic REG_ADDRESS = 1'b0;

   typedef struct packed {
      logic       hdr;
      logic [7:0] addr;
      logic [7:0] ctrl;
      logic [7:0] data;
      logic       last;
      logic [7:0] bcc2;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [3:0] {
      PH_FLAG,
      PH_ADDR,
      PH_CTRL,
      PH_BCC1,
      PH_DATA,
      PH_DATA2,
      PH_BCC2,
      PH_BCC22,
      PH_CLOSE
   } phase_type;

   function automatic logic needs_escape(input logic [7:0] b);
      return (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

endpackage

/* rtl/core/ifb_front.sv */
module ifb_front import ifb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_data_byte,
   input  logic         req_seq_bit,
   input  logic         req_last_byte,
   input  logic [7:0]   address_byte,
   input  q_status_type q_status,
   output logic         push,
   output desc_type     push_desc
);

   logic       in_frame_ff, in_frame_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] ctrl;
   logic [7:0] run_xor;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   assign ctrl    = req_seq_bit ? CTRL_SEQ1 : CTRL_SEQ0;
   assign run_xor = (in_frame_ff ? xor_ff : 8'h00) ^ req_data_byte;

   always_comb begin
      push_desc.hdr  = !in_frame_ff;
      push_desc.addr = address_byte;
      push_desc.ctrl = ctrl;
      push_desc.data = req_data_byte;
      push_desc.last = req_last_byte;
      push_desc.bcc2 = run_xor;
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      xor_in      = xor_ff;
      if (push) begin
         in_frame_in = !req_last_byte;
         xor_in      = req_last_byte ? 8'h00 : run_xor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         xor_ff      <= 8'h00;
      end else begin
         in_frame_ff <= in_frame_in;
         xor_ff      <= xor_in;
      end
   end

endmodule

/* rtl/core/ifb_queue.sv */
module ifb_queue import ifb_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  desc_type     push_desc,
   input  logic         pop,
   output desc_type     head,
   output q_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head           = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/ifb_back.sv */
module ifb_back import ifb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  desc_type     head,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_run_last,
   output logic         rsp_frame_done
);

   phase_type  phase_ff, phase_in;
   phase_type  cur_phase;
   logic       fire;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff;
   logic       run_last_ff;
   logic       frame_done_ff;
   logic [7:0] byte_val;
   logic       run_end;
   logic       done_val;

   assign fire      = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign cur_phase = (phase_ff == PH_FLAG && !head.hdr) ? PH_DATA : phase_ff;
   assign pop       = fire && run_end;

   always_comb begin
      byte_val = FLAG_BYTE;
      run_end  = 1'b0;
      done_val = 1'b0;
      case (cur_phase)
         PH_FLAG:  byte_val = FLAG_BYTE;
         PH_ADDR:  byte_val = head.addr;
         PH_CTRL:  byte_val = head.ctrl;
         PH_BCC1:  byte_val = head.addr ^ head.ctrl;
         PH_DATA: begin
            if (needs_escape(head.data)) begin
               byte_val = ESC_BYTE;
            end else begin
               byte_val = head.data;
               run_end  = !head.last;
            end
         end
         PH_DATA2: begin
            byte_val = head.data ^ ESC_XOR;
            run_end  = !head.last;
         end
         PH_BCC2:  byte_val = needs_escape(head.bcc2) ? ESC_BYTE : head.bcc2;
         PH_BCC22: byte_val = head.bcc2 ^ ESC_XOR;
         PH_CLOSE: begin
            byte_val = FLAG_BYTE;
            run_end  = 1'b1;
            done_val = 1'b1;
         end
         default: begin
            byte_val = FLAG_BYTE;
            run_end  = 1'b1;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         case (cur_phase)
            PH_FLAG:  phase_in = PH_ADDR;
            PH_ADDR:  phase_in = PH_CTRL;
            PH_CTRL:  phase_in = PH_BCC1;
            PH_BCC1:  phase_in = PH_DATA;
            PH_DATA: begin
               if (needs_escape(head.data)) begin
                  phase_in = PH_DATA2;
               end else begin
                  phase_in = head.last ? PH_BCC2 : PH_FLAG;
               end
            end
            PH_DATA2: phase_in = head.last ? PH_BCC2 : PH_FLAG;
            PH_BCC2:  phase_in = needs_escape(head.bcc2) ? PH_BCC22 : PH_CLOSE;
            PH_BCC22: phase_in = PH_CLOSE;
            PH_CLOSE: phase_in = PH_FLAG;
            default:  phase_in = PH_FLAG;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FLAG;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_byte_ff   <= byte_val;
         run_last_ff   <= run_end;
         frame_done_ff <= done_val;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_frame_done = frame_done_ff;

`ifndef SYNTH
   a_done_is_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && frame_done_ff) |-> (run_last_ff && out_byte_ff == FLAG_BYTE))
      else $error("frame_done on a byte that is not a closing run_last flag");
   a_fire_has_head: assert property (@(posedge clock) disable iff (reset)
      fire |-> (!q_status.empty && cur_phase == phase_ff ||
                !q_status.empty && phase_ff == PH_FLAG))
      else $error("sequencer advanced without a queued item");
   a_restart_phase: assert property (@(posedge clock) disable iff (reset)
      pop |=> (phase_ff == PH_FLAG))
      else $error("sequencer did not restart after finishing an item");
   a_escape_follow: assert property (@(posedge clock) disable iff (reset)
      (fire && (cur_phase == PH_DATA2 || cur_phase == PH_BCC22)) |->
      (rsp_valid_ff && out_byte_ff == ESC_BYTE || !rsp_valid_ff))
      else $error("escaped byte not preceded by the escape byte");
`endif

endmodule

/* rtl/core/info_frame_byte_stuffing_framer_core.sv */
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_data_byte, req_seq_bit, req_last_byte
// rsp      out        rsp_valid/rsp_stall   rsp_out_byte, rsp_run_last, rsp_frame_done
// csr      in/out     APB, pready tied high address_byte at byte address 0
//
// The back sequencer emits one byte per cycle unless stalled or empty; an item is 1 to 9 bytes:
// 1 per payload byte, +1 if escaped, +4 for a header, +2 or +3 for BCC2 and closing flag.
// Items enter one per cycle into a QUEUE_DEPTH entry queue; req_stall is high when it is full.
// Synchronous active-high reset empties the queue, closes any open frame, address back to 0x05.
// A valid output byte holds while rsp_stall is high; the queue keeps filling meanwhile.
module info_frame_byte_stuffing_framer_core import ifb_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_seq_bit,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_frame_done,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [7:0]   address_ff, address_in;
   logic         push;
   logic         pop;
   desc_type     push_desc;
   desc_type     head;
   q_status_type q_status;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_ADDRESS) ? {24'h000000, address_ff} : 32'h00000000;

   always_comb begin
      address_in = address_ff;
      if (psel && penable && pwrite && pready && paddr[2] == REG_ADDRESS) begin
         address_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff <= ADDR_RESET;
      end else begin
         address_ff <= address_in;
      end
   end

   ifb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_seq_bit   (req_seq_bit),
      .req_last_byte (req_last_byte),
      .address_byte  (address_ff),
      .q_status      (q_status),
      .push          (push),
      .push_desc     (push_desc)
   );

   ifb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   ifb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

/* tb/framer_checker.sv */
module framer_checker
   import ifb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_seq_bit,
   input  logic              req_last_byte,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [7:0]        rsp_out_byte,
   input  logic              rsp_run_last,
   input  logic              rsp_frame_done,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   input  logic              pready,
   output int unsigned       mismatch_count,
   output int unsigned       bytes_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ADDR_STATION = {REG_ADDRESS, 2'b00};

   typedef struct packed {
      logic [7:0] value;
      logic       run_last;
      logic       frame_done;
   } line_byte_type;

   line_byte_type owed_q[$];
   logic [7:0]    station_addr;
   logic          frame_open;
   logic [7:0]    payload_parity;
   int unsigned   fails;

   function automatic void owe(input logic [7:0] b, input logic done);
      line_byte_type nb;
      nb = '{value: b, run_last: 1'b0, frame_done: done};
      owed_q.push_back(nb);
   endfunction

   function automatic void owe_stuffed(input logic [7:0] b);
      if (b == FLAG_BYTE || b == ESC_BYTE) begin
         owe(ESC_BYTE, 1'b0);
         owe(b ^ ESC_XOR, 1'b0);
      end else begin
         owe(b, 1'b0);
      end
   endfunction

   function automatic void frame_item(input logic [7:0] d, input logic s, input logic l);
      logic [7:0]    ctrl;
      line_byte_type tail;
      ctrl = s ? CTRL_SEQ1 : CTRL_SEQ0;
      if (!frame_open) begin
         owe(FLAG_BYTE, 1'b0);
         owe(station_addr, 1'b0);
         owe(ctrl, 1'b0);
         owe(station_addr ^ ctrl, 1'b0);
         frame_open = 1'b1;
         payload_parity = 8'h00;
      end
      owe_stuffed(d);
      payload_parity = payload_parity ^ d;
      if (l) begin
         owe_stuffed(payload_parity);
         owe(FLAG_BYTE, 1'b1);
         frame_open = 1'b0;
         payload_parity = 8'h00;
      end
      // mark the final byte this item causes
      tail = owed_q.pop_back();
      tail.run_last = 1'b1;
      owed_q.push_back(tail);
   endfunction

   always @(posedge clock) begin
      line_byte_type got;
      line_byte_type want;
      if (reset) begin
         owed_q.delete();
         station_addr = ADDR_RESET;
         frame_open = 1'b0;
         payload_parity = 8'h00;
         fails = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{value: rsp_out_byte, run_last: rsp_run_last, frame_done: rsp_frame_done};
            if (owed_q.size() == 0) begin
               $error("unexpected item: out_byte %h run_last %b frame_done %b",
                      got.value, got.run_last, got.frame_done);
               fails++;
            end else begin
               want = owed_q.pop_front();
               if (got.value !== want.value) begin
                  $error("out_byte: expected %h, got %h", want.value, got.value);
                  fails++;
               end
               if (got.run_last !== want.run_last) begin
                  $error("run_last: expected %b, got %b", want.run_last, got.run_last);
                  fails++;
               end
               if (got.frame_done !== want.frame_done) begin
                  $error("frame_done: expected %b, got %b", want.frame_done, got.frame_done);
                  fails++;
               end
            end
         end
         if (psel && penable && pwrite && pready && paddr == ADDR_STATION) begin
            station_addr = pwdata[7:0];
         end
         if (req_valid && !req_stall) begin
            frame_item(req_data_byte, req_seq_bit, req_last_byte);
         end
      end
      mismatch_count <= fails;
      bytes_owed <= $unsigned(owed_q.size());
   end

endmodule

/* tb/testbench.sv */
module testbench;
   import ifb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ADDR_STATION = {REG_ADDRESS, 2'b00};
   localparam logic [2:0] ADDR_SPARE   = 3'd4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_seq_bit = 1'b0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_frame_done;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;
   int unsigned mismatch_count;
   int unsigned bytes_owed;
   logic        calm = 1'b0;

   info_frame_byte_stuffing_framer_core dut (.*);

   framer_checker checker_i (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 6);
   end

   task automatic send_item(input logic [7:0] d, input logic s, input logic l);
      if (!calm && $urandom_range(0, 99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_seq_bit <= s;
      req_last_byte <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bytes_owed != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] a, input logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= a;
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int unsigned sent;
      int unsigned len;
      logic [7:0]  d;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      // seq bit toggles mid-frame and must be ignored
      send_item(FLAG_BYTE, 1'b0, 1'b0);
      send_item(ESC_BYTE, 1'b1, 1'b0);
      send_item(8'h5E, 1'b0, 1'b0);
      send_item(8'h5D, 1'b1, 1'b1);
      send_item(FLAG_BYTE, 1'b1, 1'b1);
      send_item(ESC_BYTE, 1'b0, 1'b1);
      send_item(8'h11, 1'b0, 1'b0);
      send_item(8'h6F, 1'b1, 1'b1);
      send_item(8'hA5, 1'b1, 1'b0);
      send_item(8'h0F, 1'b0, 1'b0);
      send_item(8'hF0, 1'b1, 1'b1);
      drain();
      csr_write(ADDR_SPARE, 32'h0000_007E);
      send_item(8'h42, 1'b0, 1'b1);
      drain();
      csr_write(ADDR_STATION, {24'hFFFFFF, FLAG_BYTE});
      send_item(8'h01, 1'b0, 1'b1);
      drain();
      csr_write(ADDR_STATION, {24'h0, ESC_BYTE});
      send_item(8'h02, 1'b1, 1'b1);
      drain();
      csr_write(ADDR_STATION, 32'h0000_007C);
      send_item(FLAG_BYTE, 1'b1, 1'b1);
      drain();
      csr_write(ADDR_STATION, 32'h0000_00FF);
      send_item(8'h80, 1'b0, 1'b0);
      send_item(8'h7F, 1'b1, 1'b1);
      drain();
      csr_write(ADDR_STATION, 32'h0000_0000);
      send_item(8'h55, 1'b1, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         drain();
         csr_write(ADDR_STATION, $urandom());
         if (phase == 1) csr_write(ADDR_SPARE, $urandom());
         calm = (phase == 2);
         sent = 0;
         while (sent < 20) begin
            len = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0) len = $urandom_range(7, 16);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 3) == 0) d = $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
               else d = 8'($urandom());
               send_item(d, 1'($urandom()), k == len - 1);
               sent++;
               // hold the sender until all output has drained
               if (phase == 1 && sent == 10) drain();
            end
         end
      end
      calm = 1'b0;

      drain();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && bytes_owed == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #400_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/ifb_pkg.sv
rtl/core/ifb_front.sv
rtl/core/ifb_queue.sv
rtl/core/ifb_back.sv
rtl/core/info_frame_byte_stuffing_framer_core.sv
tb/framer_checker.sv
tb/testbench.sv
